[rtl/core/lrc_pkg.sv]
// shared types, register map and constants of the line rasterizer with clipping
package lrc_pkg;

    localparam int COORD_BITS_DEF = 12;

    localparam int CLIP_W     = 12;
    localparam int STRIDE_W   = 15;
    localparam int BPP_W      = 3;
    localparam int COLOR_W    = 32;
    localparam int OFFSET_W   = 25;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CLIP_WIDTH  = 4'd0,
        REG_CLIP_HEIGHT = 4'd1,
        REG_LINE_STRIDE = 4'd2,
        REG_BPP         = 4'd3
    } cfg_reg_t;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } cmd_code_t;

    localparam logic [CLIP_W-1:0]   CLIP_WIDTH_RST  = 12'd1024;
    localparam logic [CLIP_W-1:0]   CLIP_HEIGHT_RST = 12'd768;
    localparam logic [STRIDE_W-1:0] STRIDE_RST      = 15'd4096;
    localparam logic [BPP_W-1:0]    BPP_RST         = 3'd4;

    typedef struct packed {
        logic [CLIP_W-1:0]   clip_width;
        logic [CLIP_W-1:0]   clip_height;
        logic [STRIDE_W-1:0] line_stride_bytes;
        logic [BPP_W-1:0]    bytes_per_pixel;
    } cfg_t;

    typedef struct packed {
        logic start;
        logic step;
    } walk_ctrl_t;

    typedef struct packed {
        logic active;
        logic last;
    } walk_status_t;

endpackage

[rtl/core/lrc_if.sv]
// handshake channels: configuration writes, line commands and emitted points
interface lrc_cfg_if;
    import lrc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output reg_index, output data, input ready);
    modport sink   (input valid, input reg_index, input data, output ready);
endinterface

interface lrc_cmd_if #(
    parameter int COORD_BITS = lrc_pkg::COORD_BITS_DEF
);
    import lrc_pkg::*;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [COLOR_W-1:0]           pixel_color;
    modport source (output valid, output command, output start_x, output start_y,
                    output end_x, output end_y, output pixel_color, input ready);
    modport sink   (input valid, input command, input start_x, input start_y,
                    input end_x, input end_y, input pixel_color, output ready);
endinterface

interface lrc_pt_if #(
    parameter int COORD_BITS = lrc_pkg::COORD_BITS_DEF
);
    import lrc_pkg::*;
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic [COLOR_W-1:0]           out_color;
    logic                         visible;
    logic [OFFSET_W-1:0]          byte_offset;
    logic                         last;
    modport source (output valid, output point_x, output point_y, output out_color,
                    output visible, output byte_offset, output last, input ready);
    modport sink   (input valid, input point_x, input point_y, input out_color,
                    input visible, input byte_offset, input last, output ready);
endinterface

[rtl/core/lrc_cfg_regs.sv]
// configuration register file of the line rasterizer
module lrc_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    lrc_cfg_if.sink            cfg,
    output lrc_pkg::cfg_t      cfg_q
);
    import lrc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.reg_index)
                REG_CLIP_WIDTH:  cfg_next.clip_width        = cfg.data[CLIP_W-1:0];
                REG_CLIP_HEIGHT: cfg_next.clip_height       = cfg.data[CLIP_W-1:0];
                REG_LINE_STRIDE: cfg_next.line_stride_bytes = cfg.data[STRIDE_W-1:0];
                REG_BPP:         cfg_next.bytes_per_pixel   = cfg.data[BPP_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clip_width        <= CLIP_WIDTH_RST;
            cfg_reg.clip_height       <= CLIP_HEIGHT_RST;
            cfg_reg.line_stride_bytes <= STRIDE_RST;
            cfg_reg.bytes_per_pixel   <= BPP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/core/lrc_walker.sv]
// bresenham line state: endpoint setup and one error-term step per item
module lrc_walker #(
    parameter int COORD_BITS = lrc_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lrc_pkg::walk_ctrl_t           ctrl,
    input  logic signed [COORD_BITS-1:0]  start_x,
    input  logic signed [COORD_BITS-1:0]  start_y,
    input  logic signed [COORD_BITS-1:0]  end_x,
    input  logic signed [COORD_BITS-1:0]  end_y,
    input  logic [lrc_pkg::COLOR_W-1:0]   pixel_color,
    output logic signed [COORD_BITS-1:0]  cur_x,
    output logic signed [COORD_BITS-1:0]  cur_y,
    output logic [lrc_pkg::COLOR_W-1:0]   line_color,
    output lrc_pkg::walk_status_t         status
);
    import lrc_pkg::*;

    localparam int ERR_W = COORD_BITS + 2;
    localparam int E2_W  = ERR_W + 1;
    localparam int DIF_W = COORD_BITS + 1;

    logic signed [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic signed [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic signed [COORD_BITS-1:0] target_x_reg, target_x_next;
    logic signed [COORD_BITS-1:0] target_y_reg, target_y_next;
    logic [COORD_BITS-1:0]        span_x_reg, span_x_next;
    logic [COORD_BITS-1:0]        span_y_reg, span_y_next;
    logic                         dir_x_neg_reg, dir_x_neg_next;
    logic                         dir_y_neg_reg, dir_y_neg_next;
    logic signed [ERR_W-1:0]      err_reg, err_next;
    logic [COLOR_W-1:0]           color_reg, color_next;
    logic                         active_reg, active_next;

    logic signed [DIF_W-1:0]      diff_x, diff_y;
    logic signed [DIF_W-1:0]      abs_x, abs_y;
    logic signed [E2_W-1:0]       e2;
    logic signed [E2_W-1:0]       sx_e, sy_e, err_sum;
    logic                         move_x, move_y;
    logic                         at_end;

    assign diff_x = DIF_W'(start_x) - DIF_W'(end_x);
    assign diff_y = DIF_W'(start_y) - DIF_W'(end_y);
    assign abs_x  = diff_x[DIF_W-1] ? -diff_x : diff_x;
    assign abs_y  = diff_y[DIF_W-1] ? -diff_y : diff_y;

    assign at_end = (cur_x_reg == target_x_reg) && (cur_y_reg == target_y_reg);
    assign e2     = {err_reg, 1'b0};
    assign sx_e   = $signed(E2_W'(span_x_reg));
    assign sy_e   = $signed(E2_W'(span_y_reg));
    assign move_x = e2 > -sy_e;
    assign move_y = e2 < sx_e;
    assign err_sum = E2_W'(err_reg) - (move_x ? sy_e : '0) + (move_y ? sx_e : '0);

    always_comb
    begin
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        target_x_next  = target_x_reg;
        target_y_next  = target_y_reg;
        span_x_next    = span_x_reg;
        span_y_next    = span_y_reg;
        dir_x_neg_next = dir_x_neg_reg;
        dir_y_neg_next = dir_y_neg_reg;
        err_next       = err_reg;
        color_next     = color_reg;
        active_next    = active_reg;
        priority if (ctrl.start)
        begin
            cur_x_next     = start_x;
            cur_y_next     = start_y;
            target_x_next  = end_x;
            target_y_next  = end_y;
            span_x_next    = abs_x[COORD_BITS-1:0];
            span_y_next    = abs_y[COORD_BITS-1:0];
            dir_x_neg_next = !diff_x[DIF_W-1];
            dir_y_neg_next = !diff_y[DIF_W-1];
            err_next       = ERR_W'(abs_x) - ERR_W'(abs_y);
            color_next     = pixel_color;
            active_next    = 1'b1;
        end
        else if (ctrl.step && active_reg)
        begin
            if (at_end)
            begin
                active_next = 1'b0;
            end
            else
            begin
                err_next = err_sum[ERR_W-1:0];
                if (move_x)
                begin
                    cur_x_next = dir_x_neg_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
                end
                if (move_y)
                begin
                    cur_y_next = dir_y_neg_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            target_x_reg  <= '0;
            target_y_reg  <= '0;
            span_x_reg    <= '0;
            span_y_reg    <= '0;
            dir_x_neg_reg <= 1'b0;
            dir_y_neg_reg <= 1'b0;
            err_reg       <= '0;
            color_reg     <= '0;
            active_reg    <= 1'b0;
        end
        else
        begin
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            target_x_reg  <= target_x_next;
            target_y_reg  <= target_y_next;
            span_x_reg    <= span_x_next;
            span_y_reg    <= span_y_next;
            dir_x_neg_reg <= dir_x_neg_next;
            dir_y_neg_reg <= dir_y_neg_next;
            err_reg       <= err_next;
            color_reg     <= color_next;
            active_reg    <= active_next;
        end
    end

    assign cur_x         = cur_x_reg;
    assign cur_y         = cur_y_reg;
    assign line_color    = color_reg;
    assign status.active = active_reg;
    assign status.last   = at_end;

endmodule

[rtl/core/line_rasterizer_with_clip.sv]
// top level of the line rasterizer: clipping, byte offset and result register
//
//  channel  dir  handshake      payload
//  cfg      in   valid/ready    reg_index, data (always ready)
//  cmd      in   valid/ready    command, start_x, start_y, end_x, end_y, pixel_color
//  pt       out  valid/ready    point_x, point_y, out_color, visible, byte_offset, last
//
// one command item per cycle when ready; a step's point appears on pt the next cycle
// the line state step and the y*stride multiply-add sit in that one cycle
// cmd.ready drops only while a point is held in the result register and pt is stalled
// reset clears the line state, loads the register defaults and empties the result
module line_rasterizer_with_clip #(
    parameter int COORD_BITS = lrc_pkg::COORD_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    lrc_cfg_if.sink     cfg,
    lrc_cmd_if.sink     cmd,
    lrc_pt_if.source    pt
);
    import lrc_pkg::*;

    localparam int CMP_W = (COORD_BITS > CLIP_W ? COORD_BITS : CLIP_W) + 1;
    localparam int MAC_W = COORD_BITS + STRIDE_W + 1;

    cfg_t                         cfg_q;
    walk_ctrl_t                   ctrl;
    walk_status_t                 status;
    logic signed [COORD_BITS-1:0] cur_x, cur_y;
    logic [COLOR_W-1:0]           line_color;

    logic                         accept;
    logic                         emit;
    logic                         vis;
    logic [MAC_W-1:0]             prod_y, prod_x, mac;
    logic [OFFSET_W-1:0]          offset;

    logic                         valid_reg, valid_next;
    logic signed [COORD_BITS-1:0] px_reg, py_reg;
    logic [COLOR_W-1:0]           color_reg;
    logic                         vis_reg;
    logic [OFFSET_W-1:0]          offset_reg;
    logic                         last_reg;

    lrc_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    assign cmd.ready  = !valid_reg || pt.ready;
    assign accept     = cmd.valid && cmd.ready;
    assign ctrl.start = accept && (cmd.command == CMD_START);
    assign ctrl.step  = accept && (cmd.command == CMD_STEP);
    assign emit       = ctrl.step && status.active;

    lrc_walker #(
        .COORD_BITS (COORD_BITS)
    ) u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .start_x     (cmd.start_x),
        .start_y     (cmd.start_y),
        .end_x       (cmd.end_x),
        .end_y       (cmd.end_y),
        .pixel_color (cmd.pixel_color),
        .cur_x       (cur_x),
        .cur_y       (cur_y),
        .line_color  (line_color),
        .status      (status)
    );

    assign vis = !cur_x[COORD_BITS-1] && !cur_y[COORD_BITS-1]
              && (CMP_W'($unsigned(cur_x)) < CMP_W'(cfg_q.clip_width))
              && (CMP_W'($unsigned(cur_y)) < CMP_W'(cfg_q.clip_height));

    assign prod_y = MAC_W'($unsigned(cur_y)) * MAC_W'(cfg_q.line_stride_bytes);
    assign prod_x = MAC_W'($unsigned(cur_x)) * MAC_W'(cfg_q.bytes_per_pixel);
    assign mac    = prod_y + prod_x;
    assign offset = vis ? OFFSET_W'(mac) : '0;

    always_comb
    begin
        valid_next = valid_reg;
        priority if (emit)
        begin
            valid_next = 1'b1;
        end
        else if (pt.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            px_reg     <= cur_x;
            py_reg     <= cur_y;
            color_reg  <= line_color;
            vis_reg    <= vis;
            offset_reg <= offset;
            last_reg   <= status.last;
        end
    end

    assign pt.valid       = valid_reg;
    assign pt.point_x     = px_reg;
    assign pt.point_y     = py_reg;
    assign pt.out_color   = color_reg;
    assign pt.visible     = vis_reg;
    assign pt.byte_offset = offset_reg;
    assign pt.last        = last_reg;

endmodule
